// ===== rtl/jbt_pkg.sv =====
// ----------------------------------------------------------------------------
// jbt_pkg
// Shared types and constants of the JSON byte tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package jbt_pkg;

	typedef enum logic [4:0] {
		MODE_BETWEEN = 5'b00001,
		MODE_STRING  = 5'b00010,
		MODE_ESCAPE  = 5'b00100,
		MODE_NUMBER  = 5'b01000,
		MODE_LITERAL = 5'b10000
	} mode_t;

	typedef enum logic [3:0] {
		KIND_CHAR    = 4'd0,
		KIND_LBRACK  = 4'd1,
		KIND_RBRACK  = 4'd2,
		KIND_LBRACE  = 4'd3,
		KIND_RBRACE  = 4'd4,
		KIND_COMMA   = 4'd5,
		KIND_COLON   = 4'd6,
		KIND_STRING  = 4'd7,
		KIND_NUMBER  = 4'd8,
		KIND_TRUE    = 4'd9,
		KIND_FALSE   = 4'd10,
		KIND_NULL    = 4'd11,
		KIND_ERROR   = 4'd12
	} kind_t;

	localparam logic [1:0] PFX_NONE  = 2'd0;
	localparam logic [1:0] PFX_MINUS = 2'd1;
	localparam logic [1:0] PFX_POINT = 2'd2;
	localparam logic [1:0] PFX_VALID = 2'd3;

	localparam logic [1:0] LIT_NONE  = 2'd0;
	localparam logic [1:0] LIT_TRUE  = 2'd1;
	localparam logic [1:0] LIT_FALSE = 2'd2;
	localparam logic [1:0] LIT_NULL  = 2'd3;

	typedef struct packed {
		mode_t      mode;
		logic [1:0] prefix;
		logic [1:0] lmatch;
	} lex_state_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] text_char;
		logic [5:0] text_length;
		logic       last;
	} token_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

endpackage

`default_nettype wire

// ===== rtl/jbt_byte_if.sv =====
// ----------------------------------------------------------------------------
// jbt_byte_if
// Byte input channel: one JSON text byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface jbt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/jbt_token_if.sv =====
// ----------------------------------------------------------------------------
// jbt_token_if
// Token output channel: one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface jbt_token_if;
	logic       valid;
	logic       ready;
	logic [3:0] kind;
	logic [7:0] text_char;
	logic [5:0] text_length;
	logic       last;

	modport source (output valid, output kind, output text_char, output text_length,
		output last, input ready);
	modport sink (input valid, input kind, input text_char, input text_length,
		input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/json_byte_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// json_byte_tokenizer_unit
// Streaming JSON lexer. Takes one byte of JSON text per transaction and gives
// one result per transaction: structural tokens, each decoded string, number
// or literal character as it arrives, and an end-of-token result with the
// character count for strings, numbers, true, false and null, or an error.
// A byte that ends a number or literal can give two results; the final result
// of each byte carries last. A byte is taken every cycle while the queue has
// room: it is registered, decoded combinationally against the lexer state,
// and its results enter a four-entry queue that hands out one result per
// cycle while the output is ready. Apart from a stalled output, only runs of
// bytes that give two results each hold the input back, at the queue's
// one-result-per-cycle drain.
// ----------------------------------------------------------------------------
`default_nettype none

module json_byte_tokenizer_unit #(
	parameter int TOKEN_MAX = 64
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	jbt_byte_if.sink    text,
	jbt_token_if.source token
);
	import jbt_pkg::*;

	localparam int LEN_W = $clog2(TOKEN_MAX);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	lex_state_t       state_q;
	logic [LEN_W-1:0] len_q;
	lex_state_t       nxt_state;
	logic [LEN_W-1:0] nxt_len;
	token_t           res0;
	token_t           res1;
	logic [1:0]       cnt;
	logic             room;
	logic             advance;

	assign advance    = valid_s1 && room;
	assign text.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode   <= MODE_BETWEEN;
			state_q.prefix <= PFX_NONE;
			state_q.lmatch <= LIT_NONE;
			len_q          <= '0;
		end else if (advance) begin
			state_q <= nxt_state;
			len_q   <= nxt_len;
		end
	end

	jbt_decode #(
		.TOKEN_MAX(TOKEN_MAX)
	) u_decode (
		.in_byte   (byte_s1),
		.state     (state_q),
		.len       (len_q),
		.nxt_state (nxt_state),
		.nxt_len   (nxt_len),
		.res0      (res0),
		.res1      (res1),
		.cnt       (cnt)
	);

	jbt_token_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (advance ? cnt : 2'd0),
		.push0    (res0),
		.push1    (res1),
		.room     (room),
		.token    (token)
	);

`ifndef SYNTHESIS
	a_two_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cnt == 2'd2 |->
			state_q.mode == MODE_NUMBER || state_q.mode == MODE_LITERAL)
		else $error("two results from a byte outside a number or literal");

	a_string_error_between: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res0.kind == KIND_ERROR &&
			(state_q.mode == MODE_STRING || state_q.mode == MODE_ESCAPE) |=>
			state_q.mode == MODE_BETWEEN)
		else $error("string error did not return to between tokens");

	a_char_counts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cnt != 2'd0 && res0.kind == KIND_CHAR |=> len_q != '0)
		else $error("character taken without token length");
`endif

endmodule

`default_nettype wire

// ===== rtl/jbt_decode.sv =====
// ----------------------------------------------------------------------------
// jbt_decode
// Lexer step: from the current state and one byte, the next state and up to
// two results.
// ----------------------------------------------------------------------------
`default_nettype none

module jbt_decode #(
	parameter int TOKEN_MAX = 64
) (
	input  wire logic [7:0]                  in_byte,
	input  wire jbt_pkg::lex_state_t         state,
	input  wire logic [$clog2(TOKEN_MAX)-1:0] len,
	output jbt_pkg::lex_state_t              nxt_state,
	output logic [$clog2(TOKEN_MAX)-1:0]     nxt_len,
	output jbt_pkg::token_t                  res0,
	output jbt_pkg::token_t                  res1,
	output logic [1:0]                       cnt
);
	import jbt_pkg::*;

	localparam int LEN_W = $clog2(TOKEN_MAX);
	localparam logic [LEN_W:0] LEN_LIMIT = (LEN_W+1)'(TOKEN_MAX);

	localparam logic [7:0] C_SPACE  = 8'h20;
	localparam logic [7:0] C_TAB    = 8'h09;
	localparam logic [7:0] C_LF     = 8'h0a;
	localparam logic [7:0] C_CR     = 8'h0d;
	localparam logic [7:0] C_LBRACK = 8'h5b;
	localparam logic [7:0] C_RBRACK = 8'h5d;
	localparam logic [7:0] C_LBRACE = 8'h7b;
	localparam logic [7:0] C_RBRACE = 8'h7d;
	localparam logic [7:0] C_COMMA  = 8'h2c;
	localparam logic [7:0] C_COLON  = 8'h3a;
	localparam logic [7:0] C_QUOTE  = 8'h22;
	localparam logic [7:0] C_BSLASH = 8'h5c;
	localparam logic [7:0] C_SLASH  = 8'h2f;
	localparam logic [7:0] C_MINUS  = 8'h2d;
	localparam logic [7:0] C_PLUS   = 8'h2b;
	localparam logic [7:0] C_POINT  = 8'h2e;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_num_char(input logic [7:0] c);
		return is_digit(c) || c == C_MINUS || c == C_PLUS || c == C_POINT ||
			c == "e" || c == "E";
	endfunction

	// {valid, decoded character}
	function automatic logic [8:0] esc_decode(input logic [7:0] c);
		logic [8:0] r;
		case (c)
			C_QUOTE:  r = {1'b1, C_QUOTE};
			C_BSLASH: r = {1'b1, C_BSLASH};
			C_SLASH:  r = {1'b1, C_SLASH};
			"b":      r = {1'b1, 8'h08};
			"f":      r = {1'b1, 8'h0c};
			"n":      r = {1'b1, C_LF};
			"r":      r = {1'b1, C_CR};
			"t":      r = {1'b1, C_TAB};
			default:  r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] word_len(input logic [1:0] w);
		logic [2:0] r;
		case (w)
			2'd0:    r = 3'd4;
			2'd1:    r = 3'd5;
			2'd2:    r = 3'd4;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] word_char(input logic [1:0] w, input logic [2:0] i);
		logic [7:0] r;
		case ({w, i})
			5'b00_000: r = "t";
			5'b00_001: r = "r";
			5'b00_010: r = "u";
			5'b00_011: r = "e";
			5'b01_000: r = "f";
			5'b01_001: r = "a";
			5'b01_010: r = "l";
			5'b01_011: r = "s";
			5'b01_100: r = "e";
			5'b10_000: r = "n";
			5'b10_001: r = "u";
			5'b10_010: r = "l";
			5'b10_011: r = "l";
			default:   r = 8'h00;
		endcase
		return r;
	endfunction

	logic [8:0]       len9;
	logic [LEN_W:0]   len_inc;
	logic             ovf;
	logic [5:0]       len_out;
	logic [8:0]       esc;
	logic [7:0]       tk_char;
	token_t           tk_res;
	logic [LEN_W-1:0] tk_len;
	logic [1:0]       lm_w;
	logic             bw_emit;
	token_t           bw_res;
	lex_state_t       bw_state;
	logic [LEN_W-1:0] bw_len;

	assign len9    = 9'(len);
	assign len_inc = {1'b0, len} + (LEN_W+1)'(1);
	assign ovf     = len_inc >= LEN_LIMIT;
	assign len_out = (len9 > 9'd63) ? 6'd63 : len9[5:0];
	assign esc     = esc_decode(in_byte);
	assign tk_char = (state.mode == MODE_ESCAPE) ? esc[7:0] : in_byte;
	assign lm_w    = state.lmatch - 2'd1;

	always_comb begin
		tk_res = '0;
		if (ovf) begin
			tk_res.kind = KIND_ERROR;
			tk_len      = len;
		end else begin
			tk_res.kind      = KIND_CHAR;
			tk_res.text_char = tk_char;
			tk_len           = len_inc[LEN_W-1:0];
		end
	end

	always_comb begin
		bw_emit        = 1'b0;
		bw_res         = '0;
		bw_state       = state;
		bw_state.mode  = MODE_BETWEEN;
		bw_len         = len;
		case (in_byte)
			C_SPACE, C_TAB, C_LF, C_CR: begin
			end
			C_LBRACK: begin
				bw_emit     = 1'b1;
				bw_res.kind = KIND_LBRACK;
			end
			C_RBRACK: begin
				bw_emit     = 1'b1;
				bw_res.kind = KIND_RBRACK;
			end
			C_LBRACE: begin
				bw_emit     = 1'b1;
				bw_res.kind = KIND_LBRACE;
			end
			C_RBRACE: begin
				bw_emit     = 1'b1;
				bw_res.kind = KIND_RBRACE;
			end
			C_COMMA: begin
				bw_emit     = 1'b1;
				bw_res.kind = KIND_COMMA;
			end
			C_COLON: begin
				bw_emit     = 1'b1;
				bw_res.kind = KIND_COLON;
			end
			C_QUOTE: begin
				bw_state.mode = MODE_STRING;
				bw_len        = '0;
			end
			default: begin
				bw_emit = 1'b1;
				if (in_byte == C_MINUS || is_digit(in_byte)) begin
					bw_state.mode    = MODE_NUMBER;
					bw_state.prefix  = is_digit(in_byte) ? PFX_VALID : PFX_MINUS;
					bw_len           = LEN_W'(1);
					bw_res.kind      = KIND_CHAR;
					bw_res.text_char = in_byte;
				end else if (is_alpha(in_byte)) begin
					bw_state.mode    = MODE_LITERAL;
					bw_state.lmatch  = (in_byte == "t") ? LIT_TRUE :
						(in_byte == "f") ? LIT_FALSE :
						(in_byte == "n") ? LIT_NULL : LIT_NONE;
					bw_len           = LEN_W'(1);
					bw_res.kind      = KIND_CHAR;
					bw_res.text_char = in_byte;
				end else begin
					bw_res.kind = KIND_ERROR;
				end
			end
		endcase
	end

	always_comb begin
		nxt_state = state;
		nxt_len   = len;
		res0      = '0;
		res1      = '0;
		cnt       = 2'd0;
		case (state.mode)
			MODE_STRING: begin
				if (in_byte == C_BSLASH) begin
					nxt_state.mode = MODE_ESCAPE;
				end else if (in_byte == C_QUOTE) begin
					nxt_state.mode   = MODE_BETWEEN;
					res0.kind        = KIND_STRING;
					res0.text_length = len_out;
					cnt              = 2'd1;
				end else begin
					res0    = tk_res;
					nxt_len = tk_len;
					cnt     = 2'd1;
					if (ovf) begin
						nxt_state.mode = MODE_BETWEEN;
					end
				end
			end
			MODE_ESCAPE: begin
				cnt = 2'd1;
				if (esc[8]) begin
					res0           = tk_res;
					nxt_len        = tk_len;
					nxt_state.mode = ovf ? MODE_BETWEEN : MODE_STRING;
				end else begin
					nxt_state.mode = MODE_BETWEEN;
					res0.kind      = KIND_ERROR;
				end
			end
			MODE_NUMBER: begin
				if (is_num_char(in_byte)) begin
					if (state.prefix == PFX_MINUS) begin
						nxt_state.prefix = is_digit(in_byte) ? PFX_VALID :
							(in_byte == C_POINT) ? PFX_POINT : PFX_NONE;
					end else if (state.prefix == PFX_POINT) begin
						nxt_state.prefix = is_digit(in_byte) ? PFX_VALID : PFX_NONE;
					end
					res0    = tk_res;
					nxt_len = tk_len;
					cnt     = 2'd1;
					if (ovf) begin
						nxt_state.mode = MODE_BETWEEN;
					end
				end else begin
					if (state.prefix == PFX_VALID && len9 != 9'd0) begin
						res0.kind        = KIND_NUMBER;
						res0.text_length = len_out;
					end else begin
						res0.kind = KIND_ERROR;
					end
					res1      = bw_res;
					cnt       = bw_emit ? 2'd2 : 2'd1;
					nxt_state = bw_state;
					nxt_len   = bw_len;
				end
			end
			MODE_LITERAL: begin
				if (is_alpha(in_byte)) begin
					if (state.lmatch != LIT_NONE) begin
						if (len9 >= 9'(word_len(lm_w)) ||
							word_char(lm_w, len9[2:0]) != in_byte) begin
							nxt_state.lmatch = LIT_NONE;
						end
					end
					res0    = tk_res;
					nxt_len = tk_len;
					cnt     = 2'd1;
					if (ovf) begin
						nxt_state.mode = MODE_BETWEEN;
					end
				end else begin
					if (state.lmatch != LIT_NONE && len9 == 9'(word_len(lm_w))) begin
						res0.kind        = kind_t'(KIND_TRUE + 4'(lm_w));
						res0.text_length = len_out;
					end else begin
						res0.kind = KIND_ERROR;
					end
					res1      = bw_res;
					cnt       = bw_emit ? 2'd2 : 2'd1;
					nxt_state = bw_state;
					nxt_len   = bw_len;
				end
			end
			default: begin
				res0      = bw_res;
				cnt       = bw_emit ? 2'd1 : 2'd0;
				nxt_state = bw_state;
				nxt_len   = bw_len;
			end
		endcase
		if (cnt == 2'd2) begin
			res1.last = 1'b1;
		end else begin
			res0.last = 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/jbt_token_queue.sv =====
// ----------------------------------------------------------------------------
// jbt_token_queue
// Small result queue: up to two results in per cycle, one out when ready.
// ----------------------------------------------------------------------------
`default_nettype none

module jbt_token_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [1:0]      push_cnt,
	input  wire jbt_pkg::token_t push0,
	input  wire jbt_pkg::token_t push1,
	output logic                 room,
	jbt_token_if.source          token
);
	import jbt_pkg::*;

	token_t             mem_q [QUEUE_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               pop;
	token_t             head;

	assign pop  = token.valid && token.ready;
	assign room = count_q <= Q_CNT_W'(QUEUE_DEPTH - 2);
	assign head = mem_q[rd_ptr_q];

	assign token.valid       = count_q != '0;
	assign token.kind        = head.kind;
	assign token.text_char   = head.text_char;
	assign token.text_length = head.text_length;
	assign token.last        = head.last;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_q + Q_PTR_W'(1)] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_PTR_W'(push_cnt);
			rd_ptr_q <= rd_ptr_q + Q_PTR_W'(pop);
			count_q  <= count_q + Q_CNT_W'(push_cnt) - Q_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb_json_byte_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_byte_tokenizer_unit
// Self-checking bench for the streaming JSON lexer. A short directed walk
// covers bad start bytes, escapes, number and literal endings, and bytes
// that give two results. Random JSON-like token streams follow, with overlong
// strings and numbers, near-miss literals and raw noise. Every result is
// checked against a behavioral lexer kept in step with each accepted byte.
// Both sides throttle at random, and the output is also held off for a long
// stretch while input keeps coming.
// ----------------------------------------------------------------------------

module tb_json_byte_tokenizer_unit;
	import jbt_pkg::*;

	localparam int TOKEN_MAX      = 64;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 400;
	localparam int PHASE_ITEMS    = 650;
	localparam int N_DIR          = 26;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef struct {
		logic [7:0] b;
		bit         typed;
		int         n;
		kind_t      k0;
		kind_t      k1;
	} lex_item_t;

	logic clk = 1'b0;
	logic arst_n;

	jbt_byte_if  text_ch ();
	jbt_token_if token_ch ();

	json_byte_tokenizer_unit #(
		.TOKEN_MAX(TOKEN_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.token(token_ch)
	);

	always #2 clk = ~clk;

	// typed rows: structural, empty and error results only
	lex_item_t dir_rows [N_DIR] = '{
		'{8'h00,     1'b1, 1, KIND_ERROR,  KIND_ERROR},
		'{8'hFF,     1'b1, 1, KIND_ERROR,  KIND_ERROR},
		'{" ",       1'b1, 0, KIND_CHAR,   KIND_CHAR},
		'{"[",       1'b1, 1, KIND_LBRACK, KIND_CHAR},
		'{"{",       1'b1, 1, KIND_LBRACE, KIND_CHAR},
		'{CH_QUOTE,  1'b1, 0, KIND_CHAR,   KIND_CHAR},
		'{8'hFF,     1'b0, 0, KIND_CHAR,   KIND_CHAR},
		'{CH_BSLASH, 1'b1, 0, KIND_CHAR,   KIND_CHAR},
		'{"n",       1'b0, 0, KIND_CHAR,   KIND_CHAR},
		'{CH_BSLASH, 1'b1, 0, KIND_CHAR,   KIND_CHAR},
		'{"u",       1'b1, 1, KIND_ERROR,  KIND_CHAR},
		'{"-",       1'b0, 0, KIND_CHAR,   KIND_CHAR},
		'{".",       1'b0, 0, KIND_CHAR,   KIND_CHAR},
		'{"7",       1'b0, 0, KIND_CHAR,   KIND_CHAR},
		'{"}",       1'b0, 0, KIND_CHAR,   KIND_CHAR},
		'{"n",       1'b0, 0, KIND_CHAR,   KIND_CHAR},
		'{"u",       1'b0, 0, KIND_CHAR,   KIND_CHAR},
		'{"l",       1'b0, 0, KIND_CHAR,   KIND_CHAR},
		'{"l",       1'b0, 0, KIND_CHAR,   KIND_CHAR},
		'{",",       1'b0, 0, KIND_CHAR,   KIND_CHAR},
		'{"q",       1'b0, 0, KIND_CHAR,   KIND_CHAR},
		'{":",       1'b1, 2, KIND_ERROR,  KIND_COLON},
		'{"-",       1'b0, 0, KIND_CHAR,   KIND_CHAR},
		'{"]",       1'b1, 2, KIND_ERROR,  KIND_RBRACK},
		'{CH_QUOTE,  1'b1, 0, KIND_CHAR,   KIND_CHAR},
		'{CH_QUOTE,  1'b0, 0, KIND_CHAR,   KIND_CHAR}
	};

	string lit_words [3] = '{"true", "false", "null"};

	// behavioral lexer state
	mode_t      lx_mode = MODE_BETWEEN;
	int         lx_len  = 0;
	logic [1:0] lx_pfx  = PFX_NONE;
	logic [1:0] lx_lit  = LIT_NONE;

	token_t    byte_tokens[$];
	token_t    expected_tokens[$];
	lex_item_t stim_q[$];

	int        tx_idle = 0;
	int        rx_idle = 0;
	int        phase = 0;
	bit        held = 1'b0;
	int        lexed = 0;
	int        bytes_taken = 0;
	int        results_checked = 0;
	int        mismatches = 0;
	int        quiet_cycles = 0;
	bit [15:0] kinds_seen = '0;

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_num_char(logic [7:0] c);
		return is_digit(c) || c == "-" || c == "+" || c == "." || c == "e" || c == "E";
	endfunction

	function automatic void emit(kind_t k, logic [7:0] ch, int len);
		token_t t;
		t.kind        = k;
		t.text_char   = ch;
		t.text_length = (len > 63) ? 6'd63 : 6'(len);
		t.last        = 1'b0;
		byte_tokens.push_back(t);
	endfunction

	function automatic void add_char(logic [7:0] ch);
		if (lx_len + 1 >= TOKEN_MAX) begin
			emit(KIND_ERROR, 8'h00, 0);
			lx_mode = MODE_BETWEEN;
		end else begin
			lx_len++;
			emit(KIND_CHAR, ch, 0);
		end
	endfunction

	function automatic void lex_between(logic [7:0] c);
		case (c)
			" ", CH_TAB, CH_LF, CH_CR: ;
			"[": emit(KIND_LBRACK, 8'h00, 0);
			"]": emit(KIND_RBRACK, 8'h00, 0);
			"{": emit(KIND_LBRACE, 8'h00, 0);
			"}": emit(KIND_RBRACE, 8'h00, 0);
			",": emit(KIND_COMMA, 8'h00, 0);
			":": emit(KIND_COLON, 8'h00, 0);
			CH_QUOTE: begin
				lx_mode = MODE_STRING;
				lx_len  = 0;
			end
			default: begin
				if (c == "-" || is_digit(c)) begin
					lx_mode = MODE_NUMBER;
					lx_len  = 0;
					lx_pfx  = is_digit(c) ? PFX_VALID : PFX_MINUS;
					add_char(c);
				end else if (is_alpha(c)) begin
					lx_mode = MODE_LITERAL;
					lx_len  = 0;
					lx_lit  = (c == "t") ? LIT_TRUE : (c == "f") ? LIT_FALSE :
						(c == "n") ? LIT_NULL : LIT_NONE;
					add_char(c);
				end else begin
					emit(KIND_ERROR, 8'h00, 0);
				end
			end
		endcase
	endfunction

	function automatic void lex_byte(logic [7:0] c);
		logic [7:0] d;
		bit         bad;
		int         w;
		bad = 1'b0;
		d   = 8'h00;
		case (lx_mode)
			MODE_STRING: begin
				if (c == CH_BSLASH) begin
					lx_mode = MODE_ESCAPE;
				end else if (c == CH_QUOTE) begin
					lx_mode = MODE_BETWEEN;
					emit(KIND_STRING, 8'h00, lx_len);
				end else begin
					add_char(c);
				end
			end
			MODE_ESCAPE: begin
				case (c)
					CH_QUOTE:  d = CH_QUOTE;
					CH_BSLASH: d = CH_BSLASH;
					"/":       d = "/";
					"b":       d = 8'h08;
					"f":       d = 8'h0C;
					"n":       d = CH_LF;
					"r":       d = CH_CR;
					"t":       d = CH_TAB;
					default:   bad = 1'b1;
				endcase
				if (bad) begin
					lx_mode = MODE_BETWEEN;
					emit(KIND_ERROR, 8'h00, 0);
				end else begin
					lx_mode = MODE_STRING;
					add_char(d);
				end
			end
			MODE_NUMBER: begin
				if (is_num_char(c)) begin
					if (lx_pfx == PFX_MINUS)
						lx_pfx = is_digit(c) ? PFX_VALID : (c == "." ? PFX_POINT : PFX_NONE);
					else if (lx_pfx == PFX_POINT)
						lx_pfx = is_digit(c) ? PFX_VALID : PFX_NONE;
					add_char(c);
				end else begin
					lx_mode = MODE_BETWEEN;
					if (lx_pfx == PFX_VALID && lx_len != 0)
						emit(KIND_NUMBER, 8'h00, lx_len);
					else
						emit(KIND_ERROR, 8'h00, 0);
					lex_between(c);
				end
			end
			MODE_LITERAL: begin
				w = int'(lx_lit) - 1;
				if (is_alpha(c)) begin
					if (lx_lit != LIT_NONE) begin
						if (lx_len >= lit_words[w].len() || lit_words[w][lx_len] != c)
							lx_lit = LIT_NONE;
					end
					add_char(c);
				end else begin
					lx_mode = MODE_BETWEEN;
					if (lx_lit != LIT_NONE && lx_len == lit_words[w].len())
						emit(kind_t'(int'(KIND_TRUE) + w), 8'h00, lx_len);
					else
						emit(KIND_ERROR, 8'h00, 0);
					lex_between(c);
				end
			end
			default: begin
				lx_mode = MODE_BETWEEN;
				lex_between(c);
			end
		endcase
	endfunction

	function automatic void accept_item(lex_item_t s);
		token_t t;
		byte_tokens.delete();
		lex_byte(s.b);
		if (s.typed) begin
			byte_tokens.delete();
			for (int i = 0; i < s.n; i++) begin
				t.kind        = (i == 0) ? s.k0 : s.k1;
				t.text_char   = 8'h00;
				t.text_length = 6'd0;
				t.last        = 1'b0;
				byte_tokens.push_back(t);
			end
		end
		if (byte_tokens.size() > 0)
			byte_tokens[$].last = 1'b1;
		foreach (byte_tokens[i]) begin
			expected_tokens.push_back(byte_tokens[i]);
			kinds_seen[byte_tokens[i].kind] = 1'b1;
		end
		bytes_taken++;
	endfunction

	function automatic logic [7:0] pick(string s);
		return s[$urandom_range(s.len() - 1)];
	endfunction

	function automatic void add_stim(logic [7:0] b, bit counted);
		lex_item_t s;
		s = '{b, 1'b0, 0, KIND_CHAR, KIND_CHAR};
		stim_q.push_back(s);
		if (counted)
			lexed++;
	endfunction

	function automatic void gen_token();
		int         r;
		int         n;
		string      w;
		logic [7:0] c;
		r = $urandom_range(99);
		if (r < 12) begin
			add_stim(pick("[]{},:"), 1'b1);
		end else if (r < 20) begin
			n = $urandom_range(1, 3);
			repeat (n) add_stim(pick(" \t\n\015"), 1'b0);
		end else if (r < 50) begin
			add_stim(CH_QUOTE, 1'b1);
			n = ($urandom_range(9) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 12);
			repeat (n) begin
				if ($urandom_range(9) == 0) begin
					add_stim(CH_BSLASH, 1'b1);
					if ($urandom_range(7) == 0)
						add_stim(8'($urandom_range(255)), 1'b1);
					else
						add_stim(pick("\"\\/bfnrt"), 1'b1);
				end else begin
					c = 8'($urandom_range(255));
					if (c == CH_QUOTE || c == CH_BSLASH)
						c = "a";
					add_stim(c, 1'b1);
				end
			end
			add_stim(CH_QUOTE, 1'b1);
		end else if (r < 72) begin
			if ($urandom_range(6) == 0) begin
				add_stim("-", 1'b1);
				n = $urandom_range(0, 4);
				repeat (n) add_stim(pick("0123456789-+.eE"), 1'b1);
			end else begin
				if ($urandom_range(2) == 0) begin
					add_stim("-", 1'b1);
					if ($urandom_range(4) == 0)
						add_stim(".", 1'b1);
				end
				n = ($urandom_range(19) == 0) ? $urandom_range(58, 66) : $urandom_range(1, 4);
				repeat (n) add_stim(pick("0123456789"), 1'b1);
				if ($urandom_range(3) == 0) begin
					add_stim(".", 1'b1);
					n = $urandom_range(1, 3);
					repeat (n) add_stim(pick("0123456789"), 1'b1);
				end
				if ($urandom_range(4) == 0) begin
					add_stim(pick("eE"), 1'b1);
					if ($urandom_range(1) == 0)
						add_stim(pick("+-"), 1'b1);
					n = $urandom_range(1, 2);
					repeat (n) add_stim(pick("0123456789"), 1'b1);
				end
			end
			if ($urandom_range(4) != 0)
				add_stim(pick(",]}: \t"), 1'b1);
		end else if (r < 88) begin
			w = lit_words[$urandom_range(2)];
			r = $urandom_range(99);
			if (r < 60) begin
				for (int i = 0; i < w.len(); i++) add_stim(w[i], 1'b1);
			end else if (r < 85) begin
				n = $urandom_range(1, w.len() + 1);
				for (int i = 0; i < n; i++)
					add_stim((i < w.len()) ? w[i] : pick("elsux"), 1'b1);
			end else begin
				n = $urandom_range(1, 6);
				repeat (n)
					add_stim(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"), 1'b1);
			end
			if ($urandom_range(4) != 0)
				add_stim(pick(",]}: \n"), 1'b1);
		end else begin
			n = $urandom_range(1, 3);
			repeat (n) add_stim(8'($urandom_range(255)), 1'b1);
		end
	endfunction

	function automatic void make_random(int target);
		lexed = 0;
		while (lexed < target)
			gen_token();
	endfunction

	task automatic send_items();
		lex_item_t s;
		while (stim_q.size() > 0) begin
			s = stim_q.pop_front();
			while ($urandom_range(99) < tx_idle) begin
				text_ch.valid <= 1'b0;
				@(posedge clk);
			end
			text_ch.valid   <= 1'b1;
			text_ch.in_byte <= s.b;
			do
				@(posedge clk);
			while (!text_ch.ready);
			accept_item(s);
		end
	endtask

	// output side: random throttle, plus one long hold at the start of phase 3
	initial begin
		token_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (phase == 3 && !held) begin
				held = 1'b1;
				repeat (HOLD_CYCLES) begin
					token_ch.ready <= 1'b0;
					@(posedge clk);
				end
			end
			token_ch.ready <= ($urandom_range(99) >= rx_idle);
			@(posedge clk);
		end
	end

	always @(posedge clk) begin : check_results
		token_t want;
		if (token_ch.valid && token_ch.ready) begin
			if (expected_tokens.size() == 0) begin
				$error("unexpected result: kind %0d char %0d length %0d last %0d",
					token_ch.kind, token_ch.text_char, token_ch.text_length, token_ch.last);
				mismatches++;
			end else begin
				want = expected_tokens.pop_front();
				results_checked++;
				if (token_ch.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, token_ch.kind);
					mismatches++;
				end
				if (token_ch.text_char !== want.text_char) begin
					$error("text_char: expected %0d, got %0d", want.text_char,
						token_ch.text_char);
					mismatches++;
				end
				if (token_ch.text_length !== want.text_length) begin
					$error("text_length: expected %0d, got %0d", want.text_length,
						token_ch.text_length);
					mismatches++;
				end
				if (token_ch.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, token_ch.last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((text_ch.valid && text_ch.ready) || (token_ch.valid && token_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_json_byte_tokenizer_unit: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n          <= 1'b0;
		text_ch.valid   <= 1'b0;
		text_ch.in_byte <= 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		phase   = 1;
		tx_idle = 33;
		rx_idle = 81;
		foreach (dir_rows[i]) stim_q.push_back(dir_rows[i]);
		make_random(PHASE_ITEMS);
		send_items();

		phase   = 2;
		tx_idle = 81;
		rx_idle = 33;
		make_random(PHASE_ITEMS);
		send_items();

		// keep offering while the output is held off
		phase   = 3;
		tx_idle = 0;
		rx_idle = 0;
		make_random(PHASE_ITEMS);
		send_items();

		text_ch.valid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d bytes under three throttle mixes and a %0d-cycle output hold",
			bytes_taken, HOLD_CYCLES);
		$display("compared %0d results, %0d of 13 result kinds seen",
			results_checked, $countones(kinds_seen));
		if (mismatches == 0) begin
			$display("tb_json_byte_tokenizer_unit: done, clean");
		end else begin
			$display("tb_json_byte_tokenizer_unit: done, errors");
		end
		$finish;
	end

endmodule
